>>> rtl/drg_pkg.sv
// Shared constants, widths and saturation helper for the distance residual unit.
package drg_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int K_W             = 32;
	localparam int OUT_W           = 32;

	localparam logic [K_W-1:0]   STIFF_RESET = 32'h0001_0000;
	localparam logic [OUT_W-1:0] POS_LIM     = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] NEG_LIM     = 32'h8000_0000;

	function automatic int max_i(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Clamp a quotient magnitude and apply the sign.
	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic ovf,
		input logic [OUT_W-1:0] q);
		logic [OUT_W-1:0] m;
		if (neg) begin
			m = (ovf || q > NEG_LIM) ? NEG_LIM : q;
			sat_out = '0 - m;
		end else begin
			sat_out = (ovf || q > POS_LIM) ? POS_LIM : q;
		end
	endfunction

endpackage

>>> rtl/drg_if.sv
// Request, result and stiffness write channels.
interface drg_in_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] first_x;
	logic signed [CW-1:0] first_y;
	logic signed [CW-1:0] first_z;
	logic signed [CW-1:0] second_x;
	logic signed [CW-1:0] second_y;
	logic signed [CW-1:0] second_z;
	logic [CW-2:0] rest_length;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		rest_length, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		rest_length, output ready);
endinterface

interface drg_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] residual;
	logic signed [31:0] grad_first_x;
	logic signed [31:0] grad_first_y;
	logic signed [31:0] grad_first_z;
	logic signed [31:0] grad_second_x;
	logic signed [31:0] grad_second_y;
	logic signed [31:0] grad_second_z;
	logic degenerate;

	modport source (output valid, residual, grad_first_x, grad_first_y, grad_first_z,
		grad_second_x, grad_second_y, grad_second_z, degenerate, input ready);
	modport sink (input valid, residual, grad_first_x, grad_first_y, grad_first_z,
		grad_second_x, grad_second_y, grad_second_z, degenerate, output ready);
endinterface

interface drg_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] stiffness;

	modport source (output valid, stiffness, input ready);
	modport sink (input valid, stiffness, output ready);
endinterface

>>> rtl/distance_residual_and_gradient.sv
// Distance constraint residual and gradient unit, pipelined one request per cycle unless the output stalls.
// The path is a square, a bit-per-cell square root chain, products, then four 32-cell
// divider chains in parallel.
// Throughput: one request per cycle; the whole pipe holds while a result waits unaccepted.
// Reset clears all valid bits and sets stiffness to 1.0 (65536).
module distance_residual_and_gradient import drg_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	drg_cfg_if.sink    cfg,
	drg_in_if.sink     item,
	drg_out_if.source  result
);
	localparam int CW    = COORD_WIDTH;
	localparam int MAG_W = CW;
	localparam int D_W   = CW + 1;
	localparam int SUM_W = 2 * D_W;
	localparam int R_W   = CW - 1;
	localparam int QW    = OUT_W;
	localparam int SD    = 3 + D_W;
	localparam int LAT   = 9 + D_W + QW;
	localparam int RN_W  = K_W + D_W;
	localparam int RW1   = max_i(RN_W, R_W + QW);
	localparam int GN_W  = K_W + MAG_W + FRAC_BITS;
	localparam int GD_W  = R_W + D_W;
	localparam int RW2   = max_i(GN_W, GD_W + QW);
	localparam int FB_W  = 9;

	logic [K_W-1:0] stiffness_q;
	logic [LAT-1:0] v_q;
	logic           adv;

	assign adv        = !v_q[LAT-1] || result.ready;
	assign item.ready = adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFF_RESET;
			v_q         <= '0;
		end else begin
			if (cfg.valid)
				stiffness_q <= cfg.stiffness;
			if (adv)
				v_q <= {v_q[LAT-2:0], item.valid};
		end
	end

	// stage 1: coordinate differences
	logic signed [CW-1:0] pa [3];
	logic signed [CW-1:0] pb [3];
	logic [CW:0]          diff [3];
	logic [CW:0]          absd [3];
	logic [MAG_W-1:0]     mag_s1 [3];
	logic [2:0]           neg_s1;
	logic [R_W-1:0]       r_s1;

	assign pa[0] = item.first_x;
	assign pa[1] = item.first_y;
	assign pa[2] = item.first_z;
	assign pb[0] = item.second_x;
	assign pb[1] = item.second_y;
	assign pb[2] = item.second_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {pa[i][CW-1], pa[i]} - {pb[i][CW-1], pb[i]};
			absd[i] = diff[i][CW] ? (CW+1)'(0) - diff[i] : diff[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= absd[i][MAG_W-1:0];
				neg_s1[i] <= diff[i][CW];
			end
			r_s1 <= (item.rest_length == '0) ? R_W'(1) : item.rest_length;
		end
	end

	// stages 2-3: squares, stage 4: sum
	logic [2*MAG_W-1:0] sq [3];
	logic [SUM_W-1:0]   sum_s4;

	for (genvar i = 0; i < 3; i++) begin : g_sq
		drg_mul #(.AW(MAG_W), .BW(MAG_W)) u_sq (
			.clk(clk), .en(adv), .a(mag_s1[i]), .b(mag_s1[i]), .p(sq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv)
			sum_s4 <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
	end

	// square root chain
	logic [SUM_W-1:0] rem_c  [D_W+1];
	logic [D_W-1:0]   root_c [D_W+1];

	assign rem_c[0]  = sum_s4;
	assign root_c[0] = '0;

	for (genvar j = 0; j < D_W; j++) begin : g_sqrt
		drg_sqrt_cell #(.SUM_W(SUM_W), .D_W(D_W), .BIT(D_W - 1 - j)) u_cell (
			.clk(clk), .en(adv),
			.rem_in(rem_c[j]), .root_in(root_c[j]),
			.rem_q(rem_c[j+1]), .root_q(root_c[j+1])
		);
	end

	// side data riding alongside squares and root
	logic [MAG_W-1:0] magd_q [SD][3];
	logic [2:0]       negd_q [SD];
	logic [R_W-1:0]   rd_q   [SD];

	always_ff @(posedge clk) begin
		if (adv) begin
			magd_q[0] <= mag_s1;
			negd_q[0] <= neg_s1;
			rd_q[0]   <= r_s1;
			for (int k = 1; k < SD; k++) begin
				magd_q[k] <= magd_q[k-1];
				negd_q[k] <= negd_q[k-1];
				rd_q[k]   <= rd_q[k-1];
			end
		end
	end

	// stage 5: distance against rest length
	logic [D_W-1:0]   d_c;
	logic [D_W-1:0]   r_ext;
	logic [D_W-1:0]   d_s5;
	logic [D_W-1:0]   dd_s5;
	logic             rneg_s5;
	logic             deg_s5;
	logic [MAG_W-1:0] mag_s5 [3];
	logic [2:0]       neg_s5;
	logic [R_W-1:0]   r_s5;

	assign d_c   = root_c[D_W];
	assign r_ext = D_W'(rd_q[SD-1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s5    <= d_c;
			dd_s5   <= (d_c < r_ext) ? r_ext - d_c : d_c - r_ext;
			rneg_s5 <= d_c < r_ext;
			deg_s5  <= d_c == '0;
			mag_s5  <= magd_q[SD-1];
			neg_s5  <= negd_q[SD-1];
			r_s5    <= rd_q[SD-1];
		end
	end

	// stages 6-7: products
	logic [K_W+D_W-1:0]   kdd;
	logic [R_W+D_W-1:0]   rdp;
	logic [K_W+MAG_W-1:0] kmag [3];

	drg_mul #(.AW(K_W), .BW(D_W)) u_kdd (
		.clk(clk), .en(adv), .a(stiffness_q), .b(dd_s5), .p(kdd)
	);
	drg_mul #(.AW(R_W), .BW(D_W)) u_rd (
		.clk(clk), .en(adv), .a(r_s5), .b(d_s5), .p(rdp)
	);
	for (genvar i = 0; i < 3; i++) begin : g_kmag
		drg_mul #(.AW(K_W), .BW(MAG_W)) u_kmag (
			.clk(clk), .en(adv), .a(stiffness_q), .b(mag_s5[i]), .p(kmag[i])
		);
	end

	logic           rneg_d_q [2];
	logic           deg_d_q  [2];
	logic [2:0]     neg_d_q  [2];
	logic [R_W-1:0] r_d_q    [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			rneg_d_q[0] <= rneg_s5;
			deg_d_q[0]  <= deg_s5;
			neg_d_q[0]  <= neg_s5;
			r_d_q[0]    <= r_s5;
			rneg_d_q[1] <= rneg_d_q[0];
			deg_d_q[1]  <= deg_d_q[0];
			neg_d_q[1]  <= neg_d_q[0];
			r_d_q[1]    <= r_d_q[0];
		end
	end

	// stage 8: numerators, denominators, quotient overflow check
	logic [RW1-1:0]  res_num;
	logic [RW2-1:0]  grad_num [3];
	logic [RW1-1:0]  res_rem_s8;
	logic [R_W-1:0]  res_den_s8;
	logic [RW2-1:0]  grad_rem_s8 [3];
	logic [GD_W-1:0] grad_den_s8;
	logic [FB_W-1:0] flags_s8;
	logic [3:0]      ovf_c;

	always_comb begin
		res_num  = RW1'(kdd);
		ovf_c[0] = res_num >= (RW1'(r_d_q[1]) << QW);
		for (int i = 0; i < 3; i++) begin
			grad_num[i] = RW2'(kmag[i]) << FRAC_BITS;
			ovf_c[i+1]  = grad_num[i] >= (RW2'(rdp) << QW);
		end
	end

	// flags: {rneg, deg, neg[2:0], ovf[3:0]}
	always_ff @(posedge clk) begin
		if (adv) begin
			res_rem_s8  <= res_num;
			res_den_s8  <= r_d_q[1];
			grad_rem_s8 <= grad_num;
			grad_den_s8 <= rdp;
			flags_s8    <= {rneg_d_q[1], deg_d_q[1], neg_d_q[1], ovf_c};
		end
	end

	// divider chains
	logic [RW1-1:0]  rr_rem [QW+1];
	logic [R_W-1:0]  rr_den [QW+1];
	logic [QW-1:0]   rr_q   [QW+1];

	assign rr_rem[0] = res_rem_s8;
	assign rr_den[0] = res_den_s8;
	assign rr_q[0]   = '0;

	for (genvar j = 0; j < QW; j++) begin : g_rdiv
		drg_div_cell #(.W(RW1), .DW(R_W), .QW(QW), .BIT(QW - 1 - j)) u_cell (
			.clk(clk), .en(adv),
			.rem_in(rr_rem[j]), .den_in(rr_den[j]), .q_in(rr_q[j]),
			.rem_q(rr_rem[j+1]), .den_q(rr_den[j+1]), .q_q(rr_q[j+1])
		);
	end

	logic [QW-1:0] gq [3];

	for (genvar i = 0; i < 3; i++) begin : g_glane
		logic [RW2-1:0]  g_rem [QW+1];
		logic [GD_W-1:0] g_den [QW+1];
		logic [QW-1:0]   g_q   [QW+1];

		assign g_rem[0] = grad_rem_s8[i];
		assign g_den[0] = grad_den_s8;
		assign g_q[0]   = '0;
		assign gq[i]    = g_q[QW];

		for (genvar j = 0; j < QW; j++) begin : g_gdiv
			drg_div_cell #(.W(RW2), .DW(GD_W), .QW(QW), .BIT(QW - 1 - j)) u_cell (
				.clk(clk), .en(adv),
				.rem_in(g_rem[j]), .den_in(g_den[j]), .q_in(g_q[j]),
				.rem_q(g_rem[j+1]), .den_q(g_den[j+1]), .q_q(g_q[j+1])
			);
		end
	end

	logic [FB_W-1:0] fl_q [QW];

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_q[0] <= flags_s8;
			for (int k = 1; k < QW; k++)
				fl_q[k] <= fl_q[k-1];
		end
	end

	// stage 9: saturation and output register
	logic [FB_W-1:0]  fl_end;
	logic [OUT_W-1:0] res_s9;
	logic [OUT_W-1:0] gf_s9 [3];
	logic [OUT_W-1:0] gs_s9 [3];
	logic             deg_s9;

	assign fl_end = fl_q[QW-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s9 <= sat_out(fl_end[8], fl_end[0], rr_q[QW]);
			deg_s9 <= fl_end[7];
			for (int i = 0; i < 3; i++) begin
				gf_s9[i] <= fl_end[7] ? '0 : sat_out(fl_end[4+i], fl_end[1+i], gq[i]);
				gs_s9[i] <= fl_end[7] ? '0 : sat_out(!fl_end[4+i], fl_end[1+i], gq[i]);
			end
		end
	end

	assign result.valid         = v_q[LAT-1];
	assign result.residual      = res_s9;
	assign result.grad_first_x  = gf_s9[0];
	assign result.grad_first_y  = gf_s9[1];
	assign result.grad_first_z  = gf_s9[2];
	assign result.grad_second_x = gs_s9[0];
	assign result.grad_second_y = gs_s9[1];
	assign result.grad_second_z = gs_s9[2];
	assign result.degenerate    = deg_s9;
endmodule

>>> rtl/drg_mul.sv
// Two-stage unsigned multiplier built from two partial products.
module drg_mul import drg_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;

	logic [AW+BL-1:0] pp_lo_s1;
	logic [AW+BH-1:0] pp_hi_s1;
	logic [AW+BW-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s1 <= (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
			pp_hi_s1 <= (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
			p_s2     <= (AW+BW)'(pp_lo_s1) + ((AW+BW)'(pp_hi_s1) << BL);
		end
	end

	assign p = p_s2;
endmodule

>>> rtl/drg_sqrt_cell.sv
// One root bit of the integer square root chain.
module drg_sqrt_cell import drg_pkg::*; #(
	parameter int SUM_W = 66,
	parameter int D_W   = 33,
	parameter int BIT   = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] rem_in,
	input  logic [D_W-1:0]   root_in,
	output logic [SUM_W-1:0] rem_q,
	output logic [D_W-1:0]   root_q
);
	logic [SUM_W:0] trial;
	logic           take;

	// root bits lie above BIT, so the two terms never overlap
	always_comb begin
		trial = ((SUM_W+1)'(root_in) << (BIT + 1)) | ((SUM_W+1)'(1) << (2 * BIT));
		take  = {1'b0, rem_in} >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? rem_in - trial[SUM_W-1:0] : rem_in;
			root_q <= take ? root_in | (D_W'(1) << BIT) : root_in;
		end
	end
endmodule

>>> rtl/drg_div_cell.sv
// One quotient bit of a restoring divider chain.
module drg_div_cell import drg_pkg::*; #(
	parameter int W   = 64,
	parameter int DW  = 32,
	parameter int QW  = 32,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  rem_in,
	input  logic [DW-1:0] den_in,
	input  logic [QW-1:0] q_in,
	output logic [W-1:0]  rem_q,
	output logic [DW-1:0] den_q,
	output logic [QW-1:0] q_q
);
	logic [W-1:0] shifted;
	logic         take;

	always_comb begin
		shifted = W'(den_in) << BIT;
		take    = rem_in >= shifted;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? rem_in - shifted : rem_in;
			den_q <= den_in;
			q_q   <= take ? q_in | (QW'(1) << BIT) : q_in;
		end
	end
endmodule
